FILE: src/assert_macros.svh
// assertion helpers shared by the decoder modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked property, muted while reset is held
`define ESC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// checked property, also during reset
`define ESC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: src/esc_pkg.sv
package esc_pkg;

    localparam int ESC_QUEUE_DEPTH = 4;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;

    typedef enum logic [2:0] {
        MODE_NORMAL = 3'd0,
        MODE_ESC    = 3'd1,
        MODE_XSTART = 3'd2,
        MODE_HEX    = 3'd3,
        MODE_OCT    = 3'd4
    } t_mode;

    // up to two decoded beats caused by one input byte
    typedef struct packed {
        logic [1:0] count;
        logic [7:0] ch0;
        logic       fin0;
        logic [7:0] ch1;
        logic       fin1;
    } t_cmd;

    function automatic logic is_hex(input logic [7:0] b);
        return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h66) ||
               (b >= 8'h41 && b <= 8'h46);
    endfunction

    function automatic logic is_oct(input logic [7:0] b);
        return b >= CH_ZERO && b <= 8'h37;
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] b);
        logic [7:0] v;
        if (b <= 8'h39) begin
            v = b - CH_ZERO;
        end else if (b >= 8'h61) begin
            v = b - 8'h57;
        end else begin
            v = b - 8'h37;
        end
        return v[3:0];
    endfunction

    // simple escape letters: {hit, decoded byte}
    function automatic logic [8:0] esc_map(input logic [7:0] b);
        logic [8:0] r;
        case (b)
            8'h6E:   r = {1'b1, CH_NL};
            8'h74:   r = {1'b1, CH_TAB};
            8'h76:   r = {1'b1, 8'h0B};
            8'h62:   r = {1'b1, 8'h08};
            8'h72:   r = {1'b1, 8'h0D};
            8'h66:   r = {1'b1, 8'h0C};
            8'h61:   r = {1'b1, 8'h07};
            8'h5C:   r = {1'b1, CH_BSLASH};
            8'h27:   r = {1'b1, 8'h27};
            8'h22:   r = {1'b1, 8'h22};
            8'h3F:   r = {1'b1, 8'h3F};
            default: r = {1'b0, CH_NUL};
        endcase
        return r;
    endfunction

    // append one beat to a command
    function automatic t_cmd push_beat(input t_cmd c, input logic [7:0] ch, input logic fin);
        t_cmd r;
        r = c;
        if (c.count == 2'd0) begin
            r.ch0  = ch;
            r.fin0 = fin;
        end else begin
            r.ch1  = ch;
            r.fin1 = fin;
        end
        r.count = c.count + 2'd1;
        return r;
    endfunction

endpackage

FILE: src/esc_if.sv
interface esc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;

    modport source (output valid, output char_in, input ready);
    modport sink   (input valid, input char_in, output ready);
endinterface

interface esc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_out;
    logic       final_res;

    modport source (output valid, output char_out, output final_res, input ready);
    modport sink   (input valid, input char_out, input final_res, output ready);
endinterface

FILE: src/esc_front.sv
module esc_front
    import esc_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    esc_in_if.sink i_in,
    input  logic   i_full,
    output logic   o_push,
    output t_cmd   o_cmd
);

    t_mode      r_mode, n_mode;
    logic [7:0] r_acc, n_acc;
    t_cmd       cmd;
    logic       accept;
    logic [7:0] b;
    logic [8:0] esc;

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && !i_full;
    assign b          = i_in.char_in;
    assign esc        = esc_map(b);
    assign o_push     = accept && (cmd.count != 2'd0);
    assign o_cmd      = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_NORMAL;
            r_acc  <= CH_NUL;
        end else if (accept) begin
            r_mode <= n_mode;
            r_acc  <= n_acc;
        end
    end

    always_comb begin
        logic run_normal;
        run_normal = 1'b0;
        cmd        = '0;
        n_mode     = MODE_NORMAL;
        n_acc      = r_acc;
        case (r_mode)
            MODE_ESC: begin
                if (b == CH_NUL) begin
                    cmd   = push_beat(cmd, CH_NUL, 1'b1);
                    n_acc = CH_NUL;
                end else if (esc[8]) begin
                    cmd = push_beat(cmd, esc[7:0], 1'b0);
                end else if (b == CH_X) begin
                    n_mode = MODE_XSTART;
                end else if (is_oct(b)) begin
                    n_acc  = {5'd0, b[2:0]};
                    n_mode = MODE_OCT;
                end
            end
            MODE_XSTART: begin
                if (is_hex(b)) begin
                    n_acc  = {4'd0, hex_val(b)};
                    n_mode = MODE_HEX;
                end else begin
                    cmd        = push_beat(cmd, CH_X, 1'b0);
                    run_normal = 1'b1;
                end
            end
            MODE_HEX: begin
                if (is_hex(b)) begin
                    n_acc  = {r_acc[3:0], hex_val(b)};
                    n_mode = MODE_HEX;
                end else begin
                    cmd        = push_beat(cmd, r_acc, 1'b0);
                    n_acc      = CH_NUL;
                    run_normal = 1'b1;
                end
            end
            MODE_OCT: begin
                if (is_oct(b)) begin
                    n_acc  = {r_acc[4:0], b[2:0]};
                    n_mode = MODE_OCT;
                end else begin
                    cmd   = push_beat(cmd, r_acc, 1'b0);
                    n_acc = CH_NUL;
                    // the byte after an octal run is copied as is
                    cmd   = push_beat(cmd, b, b == CH_NUL);
                end
            end
            default: begin
                run_normal = 1'b1;
            end
        endcase
        if (run_normal) begin
            if (b == CH_NUL) begin
                cmd    = push_beat(cmd, CH_NUL, 1'b1);
                n_acc  = CH_NUL;
                n_mode = MODE_NORMAL;
            end else if (b == CH_BSLASH) begin
                n_mode = MODE_ESC;
            end else begin
                cmd    = push_beat(cmd, b, 1'b0);
                n_mode = MODE_NORMAL;
            end
        end
    end

endmodule

FILE: src/esc_queue.sv
`include "assert_macros.svh"

module esc_queue
    import esc_pkg::*;
#(
    parameter int DEPTH = ESC_QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_cmd o_head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_slot [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    `ESC_ASSERT(a_no_overflow, i_clk, i_rst_n, !(i_push && o_full), "push into full queue")
    `ESC_ASSERT(a_no_underflow, i_clk, i_rst_n, !(i_pop && o_empty), "pop from empty queue")
    `ESC_ASSERT(a_empty_ptrs, i_clk, i_rst_n, o_empty |-> (r_wr_ptr == r_rd_ptr), "pointer mismatch")

endmodule

FILE: src/esc_back.sv
`include "assert_macros.svh"

module esc_back
    import esc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_empty,
    input  t_cmd       i_head,
    output logic       o_pop,
    esc_out_if.source  o_out
);

    logic       r_valid, n_valid;
    logic       r_sel, n_sel;
    logic [7:0] r_char, n_char;
    logic       r_fin, n_fin;
    logic       load;

    assign load            = !r_valid || o_out.ready;
    assign o_out.valid     = r_valid;
    assign o_out.char_out  = r_char;
    assign o_out.final_res = r_fin;

    always_comb begin
        o_pop   = 1'b0;
        n_sel   = r_sel;
        n_valid = r_valid && !o_out.ready;
        n_char  = r_char;
        n_fin   = r_fin;
        if (load && !i_empty) begin
            n_valid = 1'b1;
            if (!r_sel) begin
                n_char = i_head.ch0;
                n_fin  = i_head.fin0;
                if (i_head.count == 2'd2) begin
                    n_sel = 1'b1;
                end else begin
                    o_pop = 1'b1;
                end
            end else begin
                n_char = i_head.ch1;
                n_fin  = i_head.fin1;
                n_sel  = 1'b0;
                o_pop  = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sel   <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_sel   <= n_sel;
        end
    end

    always_ff @(posedge i_clk) begin
        r_char <= n_char;
        r_fin  <= n_fin;
    end

    `ESC_ASSERT(a_sel_holds_head, i_clk, i_rst_n, r_sel |-> !i_empty, "second beat lost its entry")
    `ESC_ASSERT(a_last_is_nul, i_clk, i_rst_n, (r_valid && r_fin) |-> (r_char == CH_NUL), "last beat not zero")

endmodule

FILE: src/c_escape_decoder_core.sv
// channel   dir  beat payload            handshake
// i_in      in   char_in[7:0]             valid / ready
// o_out     out  char_out[7:0], final_res valid / ready
//
// one input byte is accepted per cycle while the command queue has room
// each byte yields 0, 1 or 2 beats; the output register sends 1 beat per cycle while ready
// first output beat of a byte is stored in the queue, then loaded into the output register
// a stalled output fills the queue, then i_in.ready drops; escape state is kept across stalls
// i_rst_n is synchronous: decoder returns to plain copy mode, queue and output empty
module c_escape_decoder_core
    import esc_pkg::*;
#(
    parameter int QUEUE_DEPTH = ESC_QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    esc_in_if.sink     i_in,
    esc_out_if.source  o_out
);

    // front to queue
    logic full;
    logic push;
    t_cmd push_cmd;

    // queue to back
    logic empty;
    logic pop;
    t_cmd head;

    // front: escape parser, classifies each byte into a command of 0..2 beats
    esc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push),
        .o_cmd   (push_cmd)
    );

    // short queue decouples the parser from output stalls
    esc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cmd),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    // back: serializes commands into single beats through the output register
    esc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_head  (head),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

FILE: tb/c_escape_decoder_core_tb.sv
`timescale 1ns / 100ps

module c_escape_decoder_core_tb
    import esc_pkg::*;
;

    logic i_clk;
    logic i_rst_n;

    esc_in_if  in_ch ();
    esc_out_if out_ch ();

    c_escape_decoder_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // tracks the decoder state and holds the beats still to come
    class escape_scoreboard;
        typedef struct packed {
            logic [7:0] ch;
            logic       fin;
        } t_beat;

        t_mode      mode;
        logic [7:0] acc;
        t_beat      expected_beats[$];
        int         errors;

        function new();
            mode   = MODE_NORMAL;
            acc    = 8'h00;
            errors = 0;
        endfunction

        function void expect_beat(input logic [7:0] ch, input logic fin);
            t_beat e;
            e.ch  = ch;
            e.fin = fin;
            expected_beats.push_back(e);
        endfunction

        function bit hex_digit(input logic [7:0] b, output logic [3:0] v);
            logic [7:0] d;
            d = 8'h00;
            hex_digit = 1'b1;
            if (b >= "0" && b <= "9") begin
                d = b - "0";
            end else if (b >= "a" && b <= "f") begin
                d = b - "a" + 8'd10;
            end else if (b >= "A" && b <= "F") begin
                d = b - "A" + 8'd10;
            end else begin
                hex_digit = 1'b0;
            end
            v = d[3:0];
        endfunction

        function bit oct_digit(input logic [7:0] b);
            return b >= CH_ZERO && b <= "7";
        endfunction

        function void end_of_string();
            expect_beat(CH_NUL, 1'b1);
            mode = MODE_NORMAL;
            acc  = 8'h00;
        endfunction

        function void plain_byte(input logic [7:0] b);
            if (b == CH_NUL) begin
                end_of_string();
            end else if (b == CH_BSLASH) begin
                mode = MODE_ESC;
            end else begin
                mode = MODE_NORMAL;
                expect_beat(b, 1'b0);
            end
        endfunction

        // one accepted input byte: advance the state, queue what it produces
        function void note_byte(input logic [7:0] b);
            logic [3:0] hv;
            logic [7:0] od;
            od = b - CH_ZERO;
            case (mode)
                MODE_ESC: begin
                    mode = MODE_NORMAL;
                    case (b)
                        CH_NUL:    end_of_string();
                        "n":       expect_beat(CH_NL, 1'b0);
                        "t":       expect_beat(CH_TAB, 1'b0);
                        "v":       expect_beat(8'h0B, 1'b0);
                        "b":       expect_beat(8'h08, 1'b0);
                        "r":       expect_beat(8'h0D, 1'b0);
                        "f":       expect_beat(8'h0C, 1'b0);
                        "a":       expect_beat(8'h07, 1'b0);
                        CH_BSLASH: expect_beat(CH_BSLASH, 1'b0);
                        "'":       expect_beat("'", 1'b0);
                        "\"":      expect_beat("\"", 1'b0);
                        "?":       expect_beat("?", 1'b0);
                        CH_X:      mode = MODE_XSTART;
                        default: begin
                            // unknown letters vanish together with the backslash
                            if (oct_digit(b)) begin
                                acc  = {5'b0, od[2:0]};
                                mode = MODE_OCT;
                            end
                        end
                    endcase
                end
                MODE_XSTART: begin
                    if (hex_digit(b, hv)) begin
                        acc  = {4'b0, hv};
                        mode = MODE_HEX;
                    end else begin
                        expect_beat(CH_X, 1'b0);
                        plain_byte(b);
                    end
                end
                MODE_HEX: begin
                    if (hex_digit(b, hv)) begin
                        acc = {acc[3:0], hv};
                    end else begin
                        expect_beat(acc, 1'b0);
                        acc = 8'h00;
                        plain_byte(b);
                    end
                end
                MODE_OCT: begin
                    if (oct_digit(b)) begin
                        acc = {acc[4:0], od[2:0]};
                    end else begin
                        // the byte ending an octal run is copied, even a backslash
                        expect_beat(acc, 1'b0);
                        acc  = 8'h00;
                        mode = MODE_NORMAL;
                        if (b == CH_NUL) begin
                            end_of_string();
                        end else begin
                            expect_beat(b, 1'b0);
                        end
                    end
                end
                default: plain_byte(b);
            endcase
        endfunction

        function void check_beat(input logic [7:0] ch, input logic fin);
            t_beat e;
            if (expected_beats.size() == 0) begin
                $error("char_out: unexpected beat %02h (final_res %0b)", ch, fin);
                errors++;
            end else begin
                e = expected_beats.pop_front();
                if (ch !== e.ch) begin
                    $error("char_out: expected %02h, got %02h", e.ch, ch);
                    errors++;
                end
                if (fin !== e.fin) begin
                    $error("final_res: expected %0b, got %0b", e.fin, fin);
                    errors++;
                end
            end
        endfunction
    endclass

    escape_scoreboard sb;
    logic [7:0]       stim_bytes[$];
    int               in_idle_pct  = 38;
    int               out_idle_pct = 38;
    int               hold_req     = 0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #2_400_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic logic [7:0] rand_hex_char();
        string digits;
        digits = "0123456789abcdefABCDEF";
        return digits[$urandom_range(0, 21)];
    endfunction

    // one string of random escape tokens, closed by a zero byte
    function automatic void add_string();
        string      letters;
        int         tokens;
        int         n;
        logic [7:0] b;
        letters = "ntvbrfa\\'\"?";
        tokens  = $urandom_range(1, 10);
        for (int t = 0; t < tokens; t++) begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    b = 8'($urandom_range(32, 126));
                    stim_bytes.push_back(b == CH_BSLASH ? 8'h5F : b);
                end
                2, 3: begin
                    stim_bytes.push_back(CH_BSLASH);
                    stim_bytes.push_back(letters[$urandom_range(0, 10)]);
                end
                4: begin
                    stim_bytes.push_back(CH_BSLASH);
                    stim_bytes.push_back(CH_X);
                    n = $urandom_range(1, 4);
                    repeat (n) stim_bytes.push_back(rand_hex_char());
                end
                5: begin
                    stim_bytes.push_back(CH_BSLASH);
                    n = $urandom_range(1, 4);
                    repeat (n) stim_bytes.push_back(CH_ZERO + 8'($urandom_range(0, 7)));
                end
                6: begin
                    stim_bytes.push_back(CH_BSLASH);
                    stim_bytes.push_back(8'($urandom_range(1, 255)));
                end
                7: begin
                    stim_bytes.push_back(CH_BSLASH);
                    stim_bytes.push_back(CH_X);
                end
                8: stim_bytes.push_back(8'($urandom_range(0, 255)));
                default: stim_bytes.push_back(CH_BSLASH);
            endcase
        end
        stim_bytes.push_back(CH_NUL);
    endfunction

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < in_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.char_in <= b;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sb.note_byte(b);
    endtask

    // output side: check accepted beats, drive ready with random and long stalls
    initial begin
        int hold_left;
        hold_left = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready) begin
                sb.check_beat(out_ch.char_out, out_ch.final_res);
            end
            if (hold_req > 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(0, 99) >= out_idle_pct);
            end
        end
    end

    initial begin
        int         idx;
        int         wait_cycles;
        logic [7:0] b;
        sb = new();
        i_rst_n       <= 1'b0;
        in_ch.valid   <= 1'b0;
        in_ch.char_in <= 8'h00;

        // plain extremes, unknown escape, bare \x, hex and octal run ends,
        // decoded zero before the end, wrapped hex, backslash and \x at the end
        stim_bytes = '{8'hFF, 8'h01, CH_BSLASH, "q", CH_BSLASH, CH_X, "g",
                       CH_BSLASH, CH_X, "4", "1", CH_BSLASH, "n",
                       CH_BSLASH, "1", "0", "1", CH_BSLASH,
                       CH_BSLASH, CH_ZERO, CH_NUL,
                       CH_BSLASH, CH_X, "F", "f", "f", CH_BSLASH, CH_NUL,
                       CH_BSLASH, CH_X, CH_NUL};
        while (stim_bytes.size() < 1230) add_string();

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        idx = 0;
        while (stim_bytes.size() != 0) begin
            b = stim_bytes.pop_front();
            if (idx == 300) begin
                in_idle_pct  = 0;
                out_idle_pct = 0;
            end
            if (idx == 550) begin
                in_idle_pct  = 38;
                out_idle_pct = 38;
            end
            // long output stall while input keeps coming: queue fills, input backs up
            if (idx == 750) hold_req = 300;
            // input pause until the output side has caught up
            if (idx == 1000) begin
                in_ch.valid <= 1'b0;
                do @(posedge i_clk); while (sb.expected_beats.size() != 0);
            end
            send_byte(b);
            idx++;
        end
        in_ch.valid <= 1'b0;

        wait_cycles = 0;
        do begin
            @(posedge i_clk);
            wait_cycles++;
        end while (sb.expected_beats.size() != 0 && wait_cycles < 20000);

        if (sb.expected_beats.size() != 0) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            repeat (20) @(posedge i_clk);
            if (sb.errors == 0 && sb.expected_beats.size() == 0) begin
                $display("ALL CHECKS PASSED");
            end else begin
                $display("CHECKS FAILED");
            end
            $finish;
        end
    end

endmodule
